// File: hw/rtl/qnl_pkg.sv
// qnl_pkg: shared widths and types of the quaternion nlerp pipeline
// no dependencies; used by every module of the block by scoped names

package qnl_pkg;

   // blend factor one in Q1.16
   localparam logic [16:0] BLEND_ONE = 17'd65536;

   // output limits of a Q2.14 component
   localparam logic [16:0] POS_LIMIT = 17'd32767;
   localparam logic [16:0] NEG_LIMIT = 17'd32768;

   // datapath widths
   localparam int MAG_W  = 32;   // magnitude of a blended component, at most 2^31
   localparam int SUM_W  = 65;   // sum of four squares, at most 2^64
   localparam int ROOT_W = 33;   // rounded square root, at most 2^32
   localparam int QUO_W  = 17;   // quotient bits per component
   localparam int REM_W  = 50;   // long division remainder and shifted divisor

   // magnitudes and signs of the four blended components
   typedef struct packed {
      logic [3:0][MAG_W-1:0] mag;
      logic [3:0]            neg;
   } vec_type;

endpackage

// File: hw/rtl/qnl_blend.sv
// qnl_blend: dot product, shortest path blend, and sum of squares in six stages
// depends on qnl_pkg

module qnl_blend (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [15:0]           first [4],
   input  logic signed [15:0]           second [4],
   input  logic [16:0]                  blend,
   output logic                         out_valid,
   output logic [qnl_pkg::SUM_W-1:0]    sum_sq,
   output qnl_pkg::vec_type             vec
);

   // stage 1: component products and clamped blend
   logic signed [31:0] p_in [4];
   logic signed [31:0] p_ff [4];
   logic signed [15:0] a1_ff [4];
   logic signed [15:0] c1_ff [4];
   logic [16:0]        t_in, t1_ff;
   logic               v1_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_in[i] = first[i] * second[i];
      end
      t_in = (blend > qnl_pkg::BLEND_ONE) ? qnl_pkg::BLEND_ONE : blend;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff  <= p_in;
         a1_ff <= first;
         c1_ff <= second;
         t1_ff <= t_in;
      end
   end

   // stage 2: dot product sign
   logic signed [33:0] dot_in;
   logic               neg_in, neg2_ff;
   logic signed [15:0] a2_ff [4];
   logic signed [15:0] c2_ff [4];
   logic [16:0]        t2_ff;
   logic               v2_ff;

   always_comb begin
      dot_in = 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]) + 34'(p_ff[3]);
      neg_in = dot_in[33];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg2_ff <= neg_in;
         a2_ff   <= a1_ff;
         c2_ff   <= c1_ff;
         t2_ff   <= t1_ff;
      end
   end

   // stage 3: weighted products
   logic signed [16:0] sec [4];
   logic signed [17:0] wa, wb;
   logic signed [33:0] ua_in [4];
   logic signed [33:0] ua_ff [4];
   logic signed [34:0] ub_in [4];
   logic signed [34:0] ub_ff [4];
   logic               v3_ff;

   always_comb begin
      wa = $signed({1'b0, qnl_pkg::BLEND_ONE - t2_ff});
      wb = $signed({1'b0, t2_ff});
      for (int i = 0; i < 4; i++) begin
         sec[i]   = neg2_ff ? -17'(c2_ff[i]) : 17'(c2_ff[i]);
         ua_in[i] = a2_ff[i] * wa;
         ub_in[i] = sec[i] * wb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ua_ff <= ua_in;
         ub_ff <= ub_in;
      end
   end

   // stage 4: blended component, split into magnitude and sign
   logic signed [34:0] bsum [4];
   logic signed [34:0] babs [4];
   qnl_pkg::vec_type   vec_in, vec4_ff, vec5_ff, vec6_ff;
   logic               v4_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bsum[i]          = 35'(ua_ff[i]) + ub_ff[i];
         babs[i]          = bsum[i][34] ? -bsum[i] : bsum[i];
         vec_in.neg[i]    = bsum[i][34];
         vec_in.mag[i]    = babs[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec4_ff <= vec_in;
      end
   end

   // stage 5: squares
   logic [63:0] sq_in [4];
   logic [63:0] sq_ff [4];
   logic        v5_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = 64'(vec4_ff.mag[i]) * 64'(vec4_ff.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= sq_in;
         vec5_ff <= vec4_ff;
      end
   end

   // stage 6: sum of squares
   logic [qnl_pkg::SUM_W-1:0] sum_in, sum_ff;
   logic                      v6_ff;

   assign sum_in = qnl_pkg::SUM_W'(sq_ff[0]) + qnl_pkg::SUM_W'(sq_ff[1])
                 + qnl_pkg::SUM_W'(sq_ff[2]) + qnl_pkg::SUM_W'(sq_ff[3]);

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff  <= sum_in;
         vec6_ff <= vec5_ff;
      end
   end

   // valid bits of all stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign sum_sq    = sum_ff;
   assign vec       = vec6_ff;

endmodule

// File: hw/rtl/qnl_sqrt.sv
// qnl_sqrt: rounded square root, one root bit per stage plus a rounding stage
// depends on qnl_pkg

module qnl_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [qnl_pkg::SUM_W-1:0]     sum_sq,
   input  qnl_pkg::vec_type              vec_in,
   output logic                          out_valid,
   output logic [qnl_pkg::ROOT_W-1:0]    root,
   output logic                          zero,
   output qnl_pkg::vec_type              vec_out
);

   localparam int STEPS = qnl_pkg::ROOT_W;
   localparam int TW    = qnl_pkg::SUM_W + 2;

   logic [qnl_pkg::SUM_W-1:0]  rem_src [STEPS];
   logic [qnl_pkg::ROOT_W-1:0] root_src [STEPS];
   logic                       zero_src [STEPS];
   logic                       v_src [STEPS];
   qnl_pkg::vec_type           vec_src [STEPS];

   logic [qnl_pkg::SUM_W-1:0]  rem_ff [STEPS];
   logic [qnl_pkg::ROOT_W-1:0] root_ff [STEPS];
   logic                       zero_ff [STEPS];
   logic                       v_ff [STEPS];
   qnl_pkg::vec_type           vec_ff [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int BIT = STEPS - 1 - j;

      logic [TW-1:0]                term, wide_rem;
      logic                         ge;
      logic [qnl_pkg::SUM_W-1:0]    rem_in;
      logic [qnl_pkg::ROOT_W-1:0]   root_in;

      // stage inputs come from the ports or the stage before
      if (j == 0) begin : g_first
         assign rem_src[j]  = sum_sq;
         assign root_src[j] = '0;
         assign zero_src[j] = (sum_sq == '0);
         assign v_src[j]    = in_valid;
         assign vec_src[j]  = vec_in;
      end else begin : g_next
         assign rem_src[j]  = rem_ff[j-1];
         assign root_src[j] = root_ff[j-1];
         assign zero_src[j] = zero_ff[j-1];
         assign v_src[j]    = v_ff[j-1];
         assign vec_src[j]  = vec_ff[j-1];
      end

      // try setting this root bit: (root + 2^k)^2 - root^2
      always_comb begin
         term     = (TW'(root_src[j]) << (BIT + 1)) | (TW'(1) << (2 * BIT));
         wide_rem = TW'(rem_src[j]);
         ge       = (wide_rem >= term);
         rem_in   = ge ? qnl_pkg::SUM_W'(wide_rem - term) : rem_src[j];
         root_in  = ge ? (root_src[j] | (qnl_pkg::ROOT_W'(1) << BIT)) : root_src[j];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            zero_ff[j] <= zero_src[j];
            vec_ff[j]  <= vec_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_src[j];
         end
      end
   end

   // rounding to nearest: round up when the remainder exceeds the floor root
   logic [qnl_pkg::ROOT_W-1:0] r_in, r_ff;
   logic                       zr_ff, vr_ff;
   qnl_pkg::vec_type           vr_vec_ff;

   assign r_in = root_ff[STEPS-1]
               + qnl_pkg::ROOT_W'(rem_ff[STEPS-1] > qnl_pkg::SUM_W'(root_ff[STEPS-1]));

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff      <= r_in;
         zr_ff     <= zero_ff[STEPS-1];
         vr_vec_ff <= vec_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= v_ff[STEPS-1];
      end
   end

   assign out_valid = vr_ff;
   assign root      = r_ff;
   assign zero      = zr_ff;
   assign vec_out   = vr_vec_ff;

endmodule

// File: hw/rtl/qnl_div.sv
// qnl_div: rounded division of four magnitudes by the norm, one quotient bit per stage
// depends on qnl_pkg

module qnl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [qnl_pkg::ROOT_W-1:0]    root,
   input  logic                          zero_in,
   input  qnl_pkg::vec_type              vec_in,
   output logic                          out_valid,
   output logic [3:0][qnl_pkg::QUO_W-1:0] quo,
   output logic [3:0]                    neg,
   output logic                          zero_out
);

   localparam int STEPS = qnl_pkg::QUO_W;
   localparam int RW    = qnl_pkg::REM_W;

   // numerator stage: mag * 16384 + r / 2
   logic [3:0][RW-1:0]          num_in, num_ff;
   logic [qnl_pkg::ROOT_W-1:0]  r0_ff;
   logic [3:0]                  n0_ff;
   logic                        z0_ff, v0_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         num_in[i] = (RW'(vec_in.mag[i]) << 14) + RW'(root[qnl_pkg::ROOT_W-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         r0_ff  <= root;
         n0_ff  <= vec_in.neg;
         z0_ff  <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   // long division stages
   logic [3:0][RW-1:0]              rem_src [STEPS];
   logic [3:0][qnl_pkg::QUO_W-1:0]  q_src [STEPS];
   logic [qnl_pkg::ROOT_W-1:0]      r_src [STEPS];
   logic [3:0]                      n_src [STEPS];
   logic                            z_src [STEPS];
   logic                            v_src [STEPS];

   logic [3:0][RW-1:0]              rem_ff [STEPS];
   logic [3:0][qnl_pkg::QUO_W-1:0]  q_ff [STEPS];
   logic [qnl_pkg::ROOT_W-1:0]      r_ff [STEPS];
   logic [3:0]                      n_ff [STEPS];
   logic                            z_ff [STEPS];
   logic                            v_ff [STEPS];

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int BIT = STEPS - 1 - j;

      logic [RW-1:0]                   dvs;
      logic [3:0][RW-1:0]              rem_in;
      logic [3:0][qnl_pkg::QUO_W-1:0]  q_in;

      if (j == 0) begin : g_first
         assign rem_src[j] = num_ff;
         assign q_src[j]   = '0;
         assign r_src[j]   = r0_ff;
         assign n_src[j]   = n0_ff;
         assign z_src[j]   = z0_ff;
         assign v_src[j]   = v0_ff;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign q_src[j]   = q_ff[j-1];
         assign r_src[j]   = r_ff[j-1];
         assign n_src[j]   = n_ff[j-1];
         assign z_src[j]   = z_ff[j-1];
         assign v_src[j]   = v_ff[j-1];
      end

      // compare and subtract the shifted divisor in each lane
      always_comb begin
         dvs = RW'(r_src[j]) << BIT;
         for (int i = 0; i < 4; i++) begin
            if (rem_src[j][i] >= dvs) begin
               rem_in[i] = rem_src[j][i] - dvs;
               q_in[i]   = q_src[j][i] | (qnl_pkg::QUO_W'(1) << BIT);
            end else begin
               rem_in[i] = rem_src[j][i];
               q_in[i]   = q_src[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            q_ff[j]   <= q_in;
            r_ff[j]   <= r_src[j];
            n_ff[j]   <= n_src[j];
            z_ff[j]   <= z_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= v_src[j];
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign quo       = q_ff[STEPS-1];
   assign neg       = n_ff[STEPS-1];
   assign zero_out  = z_ff[STEPS-1];

endmodule

// File: hw/rtl/quaternion_nlerp.sv
// quaternion_nlerp: top level of the normalized quaternion interpolation pipeline
// depends on qnl_pkg, qnl_blend, qnl_sqrt, qnl_div

// Fully pipelined nlerp: one transaction is accepted every cycle while the pipeline
// advances. Each result passes through 6 blend stages, 33 square root bit stages
// plus one rounding stage, one numerator stage and 17 quotient bit stages, and the
// output register. The whole pipeline moves as one: it advances whenever the
// output register is empty or being taken, so req_ready follows rsp_ready when a
// result is waiting. A zero blended norm gives a zero quaternion with zero_norm set.

module quaternion_nlerp (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_first_x,
   input  logic signed [15:0] req_first_y,
   input  logic signed [15:0] req_first_z,
   input  logic signed [15:0] req_first_w,
   input  logic signed [15:0] req_second_x,
   input  logic signed [15:0] req_second_y,
   input  logic signed [15:0] req_second_z,
   input  logic signed [15:0] req_second_w,
   input  logic [16:0]        req_blend,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic               rsp_zero_norm
);

   logic adv;
   logic rsp_valid_ff;

   // pipeline advances when the output register can take a new result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   logic signed [15:0] first [4];
   logic signed [15:0] second [4];

   assign first[0]  = req_first_x;
   assign first[1]  = req_first_y;
   assign first[2]  = req_first_z;
   assign first[3]  = req_first_w;
   assign second[0] = req_second_x;
   assign second[1] = req_second_y;
   assign second[2] = req_second_z;
   assign second[3] = req_second_w;

   // blend and sum of squares
   logic                      bl_valid;
   logic [qnl_pkg::SUM_W-1:0] bl_sum;
   qnl_pkg::vec_type          bl_vec;

   qnl_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid && req_ready),
      .first     (first),
      .second    (second),
      .blend     (req_blend),
      .out_valid (bl_valid),
      .sum_sq    (bl_sum),
      .vec       (bl_vec)
   );

   // norm
   logic                       sq_valid, sq_zero;
   logic [qnl_pkg::ROOT_W-1:0] sq_root;
   qnl_pkg::vec_type           sq_vec;

   qnl_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (bl_valid),
      .sum_sq    (bl_sum),
      .vec_in    (bl_vec),
      .out_valid (sq_valid),
      .root      (sq_root),
      .zero      (sq_zero),
      .vec_out   (sq_vec)
   );

   // normalizing division
   logic                           dv_valid, dv_zero;
   logic [3:0][qnl_pkg::QUO_W-1:0] dv_quo;
   logic [3:0]                     dv_neg;

   qnl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .root      (sq_root),
      .zero_in   (sq_zero),
      .vec_in    (sq_vec),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .neg       (dv_neg),
      .zero_out  (dv_zero)
   );

   // sign, saturation and zero norm override
   logic [3:0][15:0]          comp_in, comp_ff;
   logic [qnl_pkg::QUO_W-1:0] qs;
   logic                      zero_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (dv_neg[i]) begin
            qs         = (dv_quo[i] > qnl_pkg::NEG_LIMIT) ? qnl_pkg::NEG_LIMIT : dv_quo[i];
            comp_in[i] = 16'(-qs);
         end else begin
            qs         = (dv_quo[i] > qnl_pkg::POS_LIMIT) ? qnl_pkg::POS_LIMIT : dv_quo[i];
            comp_in[i] = qs[15:0];
         end
         if (dv_zero) begin
            comp_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         comp_ff <= comp_in;
         zero_ff <= dv_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = comp_ff[0];
   assign rsp_out_y     = comp_ff[1];
   assign rsp_out_z     = comp_ff[2];
   assign rsp_out_w     = comp_ff[3];
   assign rsp_zero_norm = zero_ff;

endmodule

// File: sim/quaternion_nlerp_test.sv
// quaternion_nlerp_test: self-checking testbench of the quaternion nlerp pipeline
// drives directed and random quaternion pairs, predicts each normalized blend that the row does not type in
// depends on quaternion_nlerp and qnl_pkg

module quaternion_nlerp_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] x, y, z, w;
      logic               zero_norm;
   } nlerp_result;

   typedef struct {
      logic signed [15:0] p [4];
      logic signed [15:0] q [4];
      logic [16:0]        blend;
      logic               known;   // expected result typed into the row
      nlerp_result        res;
   } nlerp_row;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_first_x, req_first_y, req_first_z, req_first_w;
   logic signed [15:0] req_second_x, req_second_y, req_second_z, req_second_w;
   logic [16:0]        req_blend;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic               rsp_zero_norm;

   nlerp_result expected_results [$];
   int          mismatches;
   int          cycles;
   bit          quiet_phase;
   bit          stimulus_done;

   localparam int CYCLE_LIMIT = 400000;

   quaternion_nlerp u_top (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // absolute value of a signed blended component
   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // round-to-nearest integer square root of a 65 bit sum
   function automatic logic [32:0] rounded_root(input logic [64:0] s);
      logic [64:0] lo_r, hi_r, mid;
      lo_r = 0;
      hi_r = 65'h1_0000_0000;
      while (lo_r < hi_r) begin
         mid = (lo_r + hi_r + 1) >> 1;
         if (mid * mid <= s) lo_r = mid;
         else hi_r = mid - 1;
      end
      if (s - lo_r * lo_r > lo_r) lo_r = lo_r + 1;
      return lo_r[32:0];
   endfunction

   // normalized blend of two quaternions
   function automatic nlerp_result predict_nlerp(input logic signed [15:0] p [4],
                                                 input logic signed [15:0] q [4],
                                                 input logic [16:0] blend_in);
      logic signed [63:0] dot, second;
      logic signed [63:0] b [4];
      logic [64:0]        sum_sq;
      logic [63:0]        mag, quo;
      logic [32:0]        root;
      logic signed [15:0] o [4];
      logic [16:0]        t;
      nlerp_result        r;
      dot = 0;
      sum_sq = 0;
      t = (blend_in > qnl_pkg::BLEND_ONE) ? qnl_pkg::BLEND_ONE : blend_in;
      for (int i = 0; i < 4; i++) dot += 64'(p[i]) * 64'(q[i]);
      for (int i = 0; i < 4; i++) begin
         second = (dot < 0) ? -64'(q[i]) : 64'(q[i]);
         b[i] = 64'(p[i]) * $signed({47'd0, qnl_pkg::BLEND_ONE - t})
                + second * $signed({47'd0, t});
         mag = magnitude(b[i]);
         sum_sq += 65'(mag) * 65'(mag);
      end
      if (sum_sq == 0) begin
         r = '{x: 0, y: 0, z: 0, w: 0, zero_norm: 1'b1};
         return r;
      end
      root = rounded_root(sum_sq);
      for (int i = 0; i < 4; i++) begin
         mag = magnitude(b[i]);
         quo = (mag * 64'd16384 + 64'(root >> 1)) / 64'(root);
         if (b[i] < 0) o[i] = (quo > 32768) ? -16'sd32768 : -$signed(quo[15:0]);
         else o[i] = (quo > 32767) ? 16'sd32767 : $signed(quo[15:0]);
      end
      r = '{x: o[0], y: o[1], z: o[2], w: o[3], zero_norm: 1'b0};
      return r;
   endfunction

   // send one transaction and queue its expected result
   task automatic send_pair(input nlerp_row row);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_first_x  <= row.p[0];
      req_first_y  <= row.p[1];
      req_first_z  <= row.p[2];
      req_first_w  <= row.p[3];
      req_second_x <= row.q[0];
      req_second_y <= row.q[1];
      req_second_z <= row.q[2];
      req_second_w <= row.q[3];
      req_blend    <= row.blend;
      if (row.known) expected_results.push_back(row.res);
      else expected_results.push_back(predict_nlerp(row.p, row.q, row.blend));
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd16384;
         3: return $signed(16'($urandom_range(0, 16)) - 16'd8);
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic logic [16:0] random_blend();
      case ($urandom_range(0, 6))
         0: return 17'd0;
         1: return qnl_pkg::BLEND_ONE;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // stimulus: directed table then random pairs
   initial begin
      nlerp_row table_rows [$];
      nlerp_row row;
      nlerp_result zero_res;
      nlerp_row base;
      zero_res = '{x: 0, y: 0, z: 0, w: 0, zero_norm: 1'b1};
      req_valid <= 1'b0;
      req_first_x <= '0; req_first_y <= '0; req_first_z <= '0; req_first_w <= '0;
      req_second_x <= '0; req_second_y <= '0; req_second_z <= '0; req_second_w <= '0;
      req_blend <= '0;
      quiet_phase = 1'b0;
      stimulus_done = 1'b0;
      base.known = 1'b0;
      base.res = zero_res;
      base.blend = 17'd0;
      base.p = '{0, 0, 0, 0};
      base.q = '{0, 0, 0, 0};

      // all zero: zero norm
      row = base; row.known = 1'b1; table_rows.push_back(row);
      // identity to identity, t = 0 and t = 1
      row = base; row.p = '{0, 0, 0, 16384}; row.q = '{0, 0, 0, 16384};
      row.known = 1'b1; row.res = '{x: 0, y: 0, z: 0, w: 16384, zero_norm: 0};
      table_rows.push_back(row);
      row.blend = qnl_pkg::BLEND_ONE; table_rows.push_back(row);
      // blend above one saturates
      row.blend = 17'h1FFFF; table_rows.push_back(row);
      // opposite quaternions at half: negative dot, shortest path
      row = base; row.p = '{0, 0, 0, 16384}; row.q = '{0, 0, 0, -16384};
      row.blend = 17'd32768; row.known = 1'b1;
      row.res = '{x: 0, y: 0, z: 0, w: 16384, zero_norm: 0};
      table_rows.push_back(row);
      // zero dot product, not negated
      row = base; row.p = '{16384, 0, 0, 0}; row.q = '{0, 16384, 0, 0};
      row.blend = 17'd32768; table_rows.push_back(row);
      // zero first with t = 0: zero norm
      row = base; row.q = '{100, -200, 300, -400}; row.known = 1'b1;
      table_rows.push_back(row);
      // extremes of the components
      row = base; row.p = '{-32768, -32768, -32768, -32768};
      row.q = '{32767, 32767, 32767, 32767}; row.blend = 17'd1;
      table_rows.push_back(row);
      row.blend = 17'd65535; table_rows.push_back(row);
      row = base; row.p = '{32767, 32767, 32767, 32767};
      row.q = '{32767, 32767, 32767, 32767}; row.blend = 17'd40000;
      table_rows.push_back(row);
      row = base; row.p = '{-32768, 0, 0, 0}; row.known = 1'b1;
      row.res = '{x: -16384, y: 0, z: 0, w: 0, zero_norm: 0};
      table_rows.push_back(row);
      // tiny components
      row = base; row.p = '{1, 0, 0, 0}; row.q = '{0, 0, -1, 0};
      row.blend = 17'd12345; table_rows.push_back(row);
      row = base; row.p = '{1, -1, 1, -1}; row.q = '{-1, 1, -1, 1};
      row.blend = 17'd32768; table_rows.push_back(row);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (table_rows[i]) send_pair(table_rows[i]);

      for (int n = 0; n < 1000; n++) begin
         if (n == 850) quiet_phase = 1'b1;
         row = base;
         for (int k = 0; k < 4; k++) begin
            row.p[k] = random_component();
            row.q[k] = random_component();
         end
         row.blend = random_blend();
         send_pair(row);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial reset = 1'b1;

   // result side: random stalls, compare each transaction
   initial begin
      nlerp_result want;
      int stall;
      rsp_ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_x !== want.x) begin
                  $error("out_x expected %0d actual %0d", want.x, rsp_out_x);
                  mismatches++;
               end
               if (rsp_out_y !== want.y) begin
                  $error("out_y expected %0d actual %0d", want.y, rsp_out_y);
                  mismatches++;
               end
               if (rsp_out_z !== want.z) begin
                  $error("out_z expected %0d actual %0d", want.z, rsp_out_z);
                  mismatches++;
               end
               if (rsp_out_w !== want.w) begin
                  $error("out_w expected %0d actual %0d", want.w, rsp_out_w);
                  mismatches++;
               end
               if (rsp_zero_norm !== want.zero_norm) begin
                  $error("zero_norm expected %0d actual %0d", want.zero_norm,
                         rsp_zero_norm);
                  mismatches++;
               end
            end
         end
         // stall bursts
         if (stall > 0) stall--;
         else if (!quiet_phase && $urandom_range(0, 7) == 0)
            stall = $urandom_range(1, 11);
         rsp_ready <= (stall == 0);
      end
   end

   // end of run and cycle limit
   initial begin
      mismatches = 0;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("quaternion_nlerp test failed");
            $finish;
         end
         if (stimulus_done && expected_results.size() == 0) begin
            repeat (80) @(posedge clock);
            if (mismatches == 0) $display("quaternion_nlerp test passed");
            else $display("quaternion_nlerp test failed");
            $finish;
         end
      end
   end

endmodule
